[rtl/core/rcsg_pkg.sv]
package rcsg_pkg;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_INIT,
        ST_CLAMP,
        ST_SETUP,
        ST_ROWS,
        ST_DRAIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;       // capture the fields of an accepted render word
        logic write;       // store an angle table entry
        logic rd_start;    // read the table at the frame start index
        logic frame_init;  // restart center, curve and index for a new frame
        logic clamp;       // wrap the table index at the track length
        logic setup;       // prepare the per-segment row sequencer
        logic issue;       // launch one row into the pipeline
        logic finish;      // advance curve, center and index after a segment
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_en;     // pipeline may advance this cycle
        logic pipe_busy;   // rows still in flight before the output register
        logic last_y;      // the row counter sits at the final row
    } stat_t;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned ANGLE_W = 8;
    localparam int unsigned INDEX_W = 9;

endpackage

[rtl/core/rcsg_ctrl.sv]
module rcsg_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    input  logic           in_func,
    input  logic           in_first,
    output logic           in_ready,
    input  rcsg_pkg::stat_t stat,
    output rcsg_pkg::cmd_t  cmd
);
    import rcsg_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (!in_func) begin
                        cmd.write = 1'b1;
                    end else begin
                        cmd.latch  = 1'b1;
                        state_next = in_first ? ST_LOAD : ST_CLAMP;
                    end
                end
            end
            ST_LOAD: begin
                cmd.rd_start = 1'b1;
                state_next   = ST_INIT;
            end
            ST_INIT: begin
                cmd.frame_init = 1'b1;
                state_next     = ST_CLAMP;
            end
            ST_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = ST_SETUP;
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = ST_ROWS;
            end
            ST_ROWS: begin
                // One row per cycle while the output side keeps up.
                cmd.issue = stat.pipe_en;
                if (stat.pipe_en && stat.last_y) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // Segment state moves on once every row has reached the output register.
                if (!stat.pipe_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/rcsg_dpath.sv]
module rcsg_dpath #(
    parameter int unsigned TABLE_DEPTH      = 256,
    parameter int unsigned ROWS_PER_SEGMENT = 30
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  rcsg_pkg::cmd_t               cmd,
    output rcsg_pkg::stat_t              stat,
    input  logic [7:0]                   entry_index,
    input  logic signed [7:0]            entry_value,
    input  logic [7:0]                   origin_index,
    input  logic signed [15:0]           row_offset,
    input  logic [8:0]                   track_length,
    input  logic [9:0]                   screen_center,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic signed [15:0]           row_number,
    output logic signed [15:0]           left_edge,
    output logic signed [15:0]           right_edge,
    output logic                         dark_shade,
    output logic                         last_row
);
    import rcsg_pkg::*;

    localparam int unsigned AW       = $clog2(TABLE_DEPTH);
    localparam int unsigned YW       = (ROWS_PER_SEGMENT > 1) ? $clog2(ROWS_PER_SEGMENT) : 1;
    localparam int unsigned RW       = $clog2(4 * ROWS_PER_SEGMENT + 1);
    // Exact reciprocal for a 16-bit magnitude divided by the row count.
    localparam int unsigned DIV_SH   = 22;
    localparam int unsigned DIV_RCP  = ((1 << DIV_SH) + ROWS_PER_SEGMENT - 1) / ROWS_PER_SEGMENT;
    // Exact reciprocal for reducing an 8-bit index modulo the table depth.
    localparam int unsigned MOD_RCP  = (65536 + TABLE_DEPTH - 1) / TABLE_DEPTH;

    // Reduces an 8-bit table index modulo the table depth.
    function automatic logic [AW-1:0] tbl_addr(input logic [7:0] v);
        logic [23:0] prod;
        logic [7:0]  q;
        logic [15:0] r;
        prod = 24'(v) * 24'(MOD_RCP);
        q    = prod[23:16];
        r    = 16'(v) - 16'(q) * 16'(TABLE_DEPTH);
        if (TABLE_DEPTH >= 256) begin
            return AW'(v);
        end
        return r[AW-1:0];
    endfunction

    // Angle table and its registered read port.
    logic signed [ANGLE_W-1:0] mem [TABLE_DEPTH];
    logic signed [ANGLE_W-1:0] rd_data_reg;
    logic [AW-1:0]             rd_addr;

    // Frame state.
    logic signed [COORD_W-1:0] center_reg, center_next;
    logic signed [COORD_W-1:0] x_reg, x_next;
    logic signed [COORD_W-1:0] dx_reg, dx_next;
    logic [INDEX_W-1:0]        idx_reg, idx_next;
    logic [AW-1:0]             addr_reg, addr_next;
    logic [1:0]                seg_reg, seg_next;

    // Render word fields.
    logic signed [COORD_W-1:0] off_reg;
    logic [7:0]                start_reg;

    // Segment sequencer.
    logic signed [COORD_W-1:0] sum_reg;
    logic signed [COORD_W-1:0] oldmid_reg;
    logic signed [COORD_W-1:0] acc_reg;
    logic [YW-1:0]             y_reg;
    logic [RW-1:0]             row_reg;
    logic                      shade_reg;

    // Row pipeline.
    logic                      pipe_en;
    logic                      a_v_reg, b_v_reg, c_v_reg, out_v_reg;
    logic [RW-1:0]             a_row_reg, b_row_reg;
    logic signed [COORD_W-1:0] a_p_reg;
    logic                      a_last_reg, b_last_reg, c_last_reg;
    logic [COORD_W-1:0]        a_mag;
    logic [38:0]               a_prod;
    logic [COORD_W-1:0]        b_q_reg;
    logic                      b_neg_reg;
    logic [COORD_W-1:0]        b_sq;
    logic signed [COORD_W-1:0] c_mid_reg, c_half_reg, c_rownum_reg;
    logic signed [COORD_W-1:0] left_reg, right_reg, rownum_reg;
    logic                      shade_out_reg, last_out_reg;

    assign pipe_en        = !out_v_reg || out_ready;
    assign stat.pipe_en   = pipe_en;
    assign stat.pipe_busy = a_v_reg || b_v_reg || c_v_reg;
    assign stat.last_y    = (y_reg == YW'(ROWS_PER_SEGMENT - 1));

    // Table write on a write word, registered read every cycle.
    assign rd_addr = cmd.rd_start ? tbl_addr(start_reg) : addr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            mem[tbl_addr(entry_index)] <= entry_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Capture of the render word.
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            off_reg   <= row_offset;
            start_reg <= origin_index;
        end
    end

    // Frame state updates: new frame, index wrap, end of segment.
    always_comb begin
        center_next = center_reg;
        x_next      = x_reg;
        dx_next     = dx_reg;
        idx_next    = idx_reg;
        addr_next   = addr_reg;
        seg_next    = seg_reg;
        priority if (cmd.frame_init) begin
            center_next = COORD_W'(screen_center);
            x_next      = '0;
            dx_next     = {{(COORD_W - ANGLE_W + 1){rd_data_reg[ANGLE_W-1]}},
                           rd_data_reg[ANGLE_W-1:1]};
            idx_next    = INDEX_W'(start_reg);
            addr_next   = tbl_addr(start_reg);
            seg_next    = '0;
        end else if (cmd.clamp) begin
            if (idx_reg >= track_length) begin
                idx_next  = '0;
                addr_next = '0;
            end
        end else if (cmd.finish) begin
            center_next = oldmid_reg - sum_reg;
            x_next      = sum_reg;
            dx_next     = dx_reg + {{(COORD_W - ANGLE_W){rd_data_reg[ANGLE_W-1]}}, rd_data_reg};
            idx_next    = idx_reg + INDEX_W'(1);
            addr_next   = (addr_reg == AW'(TABLE_DEPTH - 1)) ? '0 : addr_reg + AW'(1);
            seg_next    = seg_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg <= COORD_W'(160);
            x_reg      <= '0;
            dx_reg     <= '0;
            idx_reg    <= '0;
            addr_reg   <= '0;
            seg_reg    <= '0;
        end else begin
            center_reg <= center_next;
            x_reg      <= x_next;
            dx_reg     <= dx_next;
            idx_reg    <= idx_next;
            addr_reg   <= addr_next;
            seg_reg    <= seg_next;
        end
    end

    // Row sequencer: the product sum*(y-1), zero for the first row, is built by repeated addition.
    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            sum_reg    <= x_reg + dx_reg;
            oldmid_reg <= center_reg;
            acc_reg    <= '0;
            y_reg      <= '0;
            row_reg    <= RW'((4 - int'(seg_reg)) * ROWS_PER_SEGMENT);
            shade_reg  <= !seg_reg[0];
        end else if (cmd.issue) begin
            y_reg   <= y_reg + YW'(1);
            row_reg <= row_reg - RW'(1);
            if (y_reg != '0) begin
                acc_reg <= acc_reg + sum_reg;
            end
        end
    end

    // Stage A sign split and reciprocal multiply.
    assign a_mag  = a_p_reg[COORD_W-1] ? (~a_p_reg + 1'b1) : a_p_reg;
    assign a_prod = 39'(a_mag) * 39'(DIV_RCP);

    // Stage B sign restore of the quotient.
    assign b_sq = b_neg_reg ? (~b_q_reg + 1'b1) : b_q_reg;

    // Pipeline valid bits, all stages stall together.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg   <= 1'b0;
            b_v_reg   <= 1'b0;
            c_v_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (pipe_en) begin
            a_v_reg   <= cmd.issue;
            b_v_reg   <= a_v_reg;
            c_v_reg   <= b_v_reg;
            out_v_reg <= c_v_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            a_row_reg     <= row_reg;
            a_p_reg       <= acc_reg;
            a_last_reg    <= stat.last_y;
            b_q_reg       <= a_prod[DIV_SH +: COORD_W];
            b_neg_reg     <= a_p_reg[COORD_W-1];
            b_row_reg     <= a_row_reg;
            b_last_reg    <= a_last_reg;
            c_mid_reg     <= oldmid_reg - b_sq;
            c_half_reg    <= COORD_W'({b_row_reg, 1'b0}) + COORD_W'(8);
            c_rownum_reg  <= off_reg + COORD_W'(b_row_reg);
            c_last_reg    <= b_last_reg;
            left_reg      <= c_mid_reg - c_half_reg;
            right_reg     <= c_mid_reg + c_half_reg;
            rownum_reg    <= c_rownum_reg;
            shade_out_reg <= shade_reg;
            last_out_reg  <= c_last_reg;
        end
    end

    assign out_valid  = out_v_reg;
    assign row_number = rownum_reg;
    assign left_edge  = left_reg;
    assign right_edge = right_reg;
    assign dark_shade = shade_out_reg;
    assign last_row   = last_out_reg;

endmodule

[rtl/core/road_curve_scanline_generator.sv]
// Pseudo-3D road scanline generator. A write word (s_tuser = 0) stores one
// signed curve angle in the table and leaves the block ready for the next
// word. A render word (s_tuser = 1) draws the next of four road segments as
// ROWS_PER_SEGMENT result words, one per cycle while m_tready holds, from the
// far row toward the viewer, each with the row number, both road edges and
// the grass shade; tlast marks the final row. A render word occupies the
// block while its rows pass the per-row sequencer and the four-stage divide
// pipeline, after the ST_LOAD and ST_INIT states (table lookup of the start
// angle) when it starts a new frame, and longer under result back-pressure.
// The next word is taken while the last result of a segment still waits.
module road_curve_scanline_generator #(
    parameter int unsigned TABLE_DEPTH      = 256,
    parameter int unsigned ROWS_PER_SEGMENT = 30
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input words.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // entry_index[7:0], entry_value[15:8], first_segment[16],
                                   // origin_index[24:17], row_offset[40:25], zero[47:41]
    input  logic        s_tuser,   // func
    // Result words.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // row_number[15:0], left_edge[31:16], right_edge[47:32]
    output logic        m_tuser,   // dark_shade
    output logic        m_tlast,   // last_row
    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rcsg_pkg::*;

    localparam logic REG_TRACK_LENGTH  = 1'b0;
    localparam logic REG_SCREEN_CENTER = 1'b1;

    logic [8:0]  track_length_reg;
    logic [9:0]  screen_center_reg;
    logic        cfg_wr;
    cmd_t        cmd;
    stat_t       stat;
    logic signed [15:0] row_number, left_edge, right_edge;
    logic        dark_shade, last_row;

    // Register writes and reads.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_length_reg  <= 9'd256;
            screen_center_reg <= 10'd160;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_TRACK_LENGTH:  track_length_reg  <= pwdata[8:0];
                REG_SCREEN_CENTER: screen_center_reg <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TRACK_LENGTH:  prdata = 32'(track_length_reg);
            REG_SCREEN_CENTER: prdata = 32'(screen_center_reg);
            default:           prdata = '0;
        endcase
    end

    rcsg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_func  (s_tuser),
        .in_first (s_tdata[16]),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rcsg_dpath #(
        .TABLE_DEPTH      (TABLE_DEPTH),
        .ROWS_PER_SEGMENT (ROWS_PER_SEGMENT)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .entry_index   (s_tdata[7:0]),
        .entry_value   (s_tdata[15:8]),
        .origin_index  (s_tdata[24:17]),
        .row_offset    (s_tdata[40:25]),
        .track_length  (track_length_reg),
        .screen_center (screen_center_reg),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .row_number    (row_number),
        .left_edge     (left_edge),
        .right_edge    (right_edge),
        .dark_shade    (dark_shade),
        .last_row      (last_row)
    );

    // Result word packing.
    assign m_tdata = {right_edge, left_edge, row_number};
    assign m_tuser = dark_shade;
    assign m_tlast = last_row;

endmodule

[rtl/core/rcsg_checker.sv]
module rcsg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // Reset leaves no result word pending.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    // A stalled result word holds its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result word changed");

    // A render word keeps the block busy for at least the next cycle.
    a_render_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("input taken right after a render word");

    // No input word is taken while a segment still has rows to deliver.
    a_mid_segment: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready in the middle of a segment");

endmodule

bind road_curve_scanline_generator rcsg_checker u_rcsg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
